@@ hdl/c3rb_pkg.sv @@
// ----------------------------------------------------------------------------
// c3rb_pkg
// Shared types and constants for the 3x3 replicate-border convolution block.
// ----------------------------------------------------------------------------
package c3rb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = SAMPLE_W * NUM_CH;
    localparam int COEF_W   = 16;
    localparam int KROW_W   = 3 * COEF_W;
    localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
    localparam int RES_W    = 29;
    localparam int POS_X_W  = 10;
    localparam int POS_Y_W  = 16;
    localparam int FW_W     = 11;
    localparam int FH_W     = 16;
    localparam int CC_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = KROW_W;

    typedef logic [PIX_W-1:0]           pix_t;
    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [RES_W-1:0]    res_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KROW_TOP    = 3'd0,
        REG_KROW_MID    = 3'd1,
        REG_KROW_BOTTOM = 3'd2,
        REG_KEEP_CH     = 3'd3,
        REG_FRAME_W     = 3'd4,
        REG_FRAME_H     = 3'd5,
        REG_CH_COUNT    = 3'd6
    } cfg_reg_t;

    // emit kinds, bit positions in the pending mask, in output order
    localparam int EMIT_INNER      = 0;
    localparam int EMIT_ROW_END    = 1;
    localparam int EMIT_LAST_ROW   = 2;
    localparam int EMIT_FRAME_END  = 3;
    localparam int EMIT_KINDS      = 4;

    // replicate-border row/column remap: {1,2,2} on the far edge
    function automatic logic [1:0] tap_sel(input logic edge_sel, input logic [1:0] k);
        logic [1:0] r;
        r = k;
        if (edge_sel && k == 2'd0)
            r = 2'd1;
        else if (edge_sel)
            r = 2'd2;
        return r;
    endfunction

endpackage

@@ hdl/c3rb_if.sv @@
// ----------------------------------------------------------------------------
// c3rb interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface c3rb_pix_if;
    logic                     valid;
    logic                     ready;
    logic [c3rb_pkg::SAMPLE_W-1:0] sample_ch0;
    logic [c3rb_pkg::SAMPLE_W-1:0] sample_ch1;
    logic [c3rb_pkg::SAMPLE_W-1:0] sample_ch2;
    modport source (output valid, sample_ch0, sample_ch1, sample_ch2, input ready);
    modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, output ready);
endinterface

interface c3rb_res_if;
    logic                             valid;
    logic                             ready;
    logic [c3rb_pkg::POS_X_W-1:0]     pos_x;
    logic [c3rb_pkg::POS_Y_W-1:0]     pos_y;
    logic signed [c3rb_pkg::RES_W-1:0] result_ch0;
    logic signed [c3rb_pkg::RES_W-1:0] result_ch1;
    logic signed [c3rb_pkg::RES_W-1:0] result_ch2;
    logic                             frame_end;
    modport source (output valid, pos_x, pos_y, result_ch0, result_ch1, result_ch2,
                    frame_end, input ready);
    modport sink   (input valid, pos_x, pos_y, result_ch0, result_ch1, result_ch2,
                    frame_end, output ready);
endinterface

interface c3rb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [c3rb_pkg::CFG_IDX_W-1:0]     index;
    logic [c3rb_pkg::CFG_DAT_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/c3rb_linebuf.sv @@
// ----------------------------------------------------------------------------
// c3rb_linebuf
// Two-row line store (older and newer row packed per column), registered read.
// ----------------------------------------------------------------------------
module c3rb_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [2*c3rb_pkg::PIX_W-1:0]      rd_data,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [2*c3rb_pkg::PIX_W-1:0]      wr_data
);
    import c3rb_pkg::*;

    logic [2*PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/c3rb_lane.sv @@
// ----------------------------------------------------------------------------
// c3rb_lane
// One channel's 3x3 dot product: registered products, then registered sum.
// ----------------------------------------------------------------------------
module c3rb_lane (
    input  logic                          clk,
    input  logic                          en,
    input  c3rb_pkg::sample_t             taps [9],
    input  c3rb_pkg::coef_t               coefs [9],
    output c3rb_pkg::res_t                sum
);
    import c3rb_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [9];
    res_t                     sum_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
                prod_reg[k] <= PROD_W'(coefs[k] * $signed({1'b0, taps[k]}));
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < 9; k++)
            sum_next = sum_next + RES_W'(prod_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum <= sum_next;
    end

endmodule

@@ hdl/c3rb_merge.sv @@
// ----------------------------------------------------------------------------
// c3rb_merge
// Combines lane sums: per-channel results or one cross-channel sum.
// ----------------------------------------------------------------------------
module c3rb_merge #(
    parameter int NLANE = 3
) (
    input  c3rb_pkg::res_t            lane_sum [NLANE],
    input  logic                      keep,
    input  logic [1:0]                nch,
    output c3rb_pkg::res_t            res [c3rb_pkg::NUM_CH]
);
    import c3rb_pkg::*;

    res_t total;

    always_comb
    begin
        total = '0;
        for (int c = 0; c < NUM_CH; c++)
            res[c] = '0;
        for (int c = 0; c < NLANE; c++)
        begin
            if (2'(c) < nch)
            begin
                total = total + lane_sum[c];
                if (keep)
                    res[c] = lane_sum[c];
            end
        end
        if (!keep)
            res[0] = total;
    end

endmodule

@@ hdl/conv3x3_replicate_border_top.sv @@
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_top
// Streaming 3x3 convolution with replicated borders over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//  - pix_in carries one pixel (three 8-bit samples) per transfer in raster
//    order; res_out carries filtered pixels tagged with pos_x/pos_y.
//  - cfg takes register writes (always ready); write only while idle.
//  - Result for (x,y) leaves once pixel (x+1,y+1) has been taken; the last
//    column and last row come out as the last pixels of a row/frame arrive,
//    so one input can give up to four results.
//  - Path of a result after the transfer that causes it: line-store read,
//    window, tap select, products, sum register, output register.
//  - Throughput: one pixel per cycle while res_out is ready; each extra
//    row-end or last-row result stalls pix_in, set by the single tap-select emitter.
//  - Reset clears counters, window and registers (kernel zero, width 640,
//    height 480, three channels, per-channel output). The line store is not
//    cleared: row 0 fills it before any read data is used.
//  - A stalled receiver freezes the whole pipeline; the output register
//    holds its transfer and pix_in.ready drops the same cycle.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int LANES     = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    c3rb_cfg_if.sink    cfg,
    c3rb_pix_if.sink    pix_in,
    c3rb_res_if.source  res_out
);
    import c3rb_pkg::*;

    localparam int IW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NLANE = (LANES < NUM_CH) ? LANES : NUM_CH;

    // configuration registers
    logic [KROW_W-1:0] krow_reg [3];
    logic              keep_reg;
    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [CC_W-1:0]   cc_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_reg[0] <= '0;
            krow_reg[1] <= '0;
            krow_reg[2] <= '0;
            keep_reg    <= 1'b1;
            fw_reg      <= FW_W'(640);
            fh_reg      <= FH_W'(480);
            cc_reg      <= CC_W'(3);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KROW_TOP:    krow_reg[0] <= cfg.data;
                REG_KROW_MID:    krow_reg[1] <= cfg.data;
                REG_KROW_BOTTOM: krow_reg[2] <= cfg.data;
                REG_KEEP_CH:     keep_reg    <= cfg.data[0];
                REG_FRAME_W:     fw_reg      <= cfg.data[FW_W-1:0];
                REG_FRAME_H:     fh_reg      <= cfg.data[FH_W-1:0];
                REG_CH_COUNT:    cc_reg      <= cfg.data[CC_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamped sizes as last index
    logic [IW-1:0]   wm1;
    logic [FH_W-1:0] hm1;
    logic [1:0]      nch;

    always_comb
    begin
        if (int'(fw_reg) < 2)
            wm1 = IW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            wm1 = IW'(MAX_WIDTH - 1);
        else
            wm1 = IW'(int'(fw_reg) - 1);
        hm1 = (fh_reg < FH_W'(2)) ? FH_W'(1) : fh_reg - FH_W'(1);
        nch = (cc_reg == '0) ? 2'd1 : cc_reg;
        if (int'(nch) > NLANE)
            nch = 2'(NLANE);
    end

    // pipeline control: everything moves when the output register can take data
    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || res_out.ready;

    logic [EMIT_KINDS-1:0] pend_reg, pend_next;
    logic                  pend_more;
    logic                  s1_valid_reg;
    logic                  s1_go;
    logic                  accept;

    assign pend_more = |(pend_reg & (pend_reg - EMIT_KINDS'(1)));
    assign s1_go     = adv && s1_valid_reg && !pend_more;
    assign pix_in.ready = adv && (!s1_valid_reg || !pend_more);
    assign accept    = pix_in.valid && pix_in.ready;

    // raster position
    logic [IW-1:0]   col_reg;
    logic [FH_W-1:0] row_reg;
    logic [IW-1:0]   cur_i;
    logic [FH_W-1:0] cur_j;
    logic            at_wend, at_hend;

    always_comb
    begin
        cur_i   = (col_reg > wm1) ? wm1 : col_reg;
        cur_j   = (row_reg > hm1) ? hm1 : row_reg;
        at_wend = (cur_i == wm1);
        at_hend = (cur_j == hm1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (at_wend)
            begin
                col_reg <= '0;
                row_reg <= at_hend ? '0 : cur_j + FH_W'(1);
            end
            else
            begin
                col_reg <= cur_i + IW'(1);
            end
        end
    end

    // stage 1: item waits here while the line store read completes
    pix_t                  s1_px_reg;
    logic [IW-1:0]         s1_i_reg;
    logic [FH_W-1:0]       s1_j_reg;
    logic                  s1_row0_reg;
    logic [EMIT_KINDS-1:0] s1_emask_reg;
    logic [2*PIX_W-1:0]    lb_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= {pix_in.sample_ch2, pix_in.sample_ch1, pix_in.sample_ch0};
            s1_i_reg    <= cur_i;
            s1_j_reg    <= cur_j;
            s1_row0_reg <= (cur_j == '0);
            s1_emask_reg[EMIT_INNER]     <= (cur_j != '0) && (cur_i != '0);
            s1_emask_reg[EMIT_ROW_END]   <= (cur_j != '0) && at_wend;
            s1_emask_reg[EMIT_LAST_ROW]  <= (cur_j != '0) && at_hend && (cur_i != '0);
            s1_emask_reg[EMIT_FRAME_END] <= (cur_j != '0) && at_hend && at_wend;
        end
    end

    // column values of rows y-2, y-1, y (top row replicated on row 0)
    pix_t up2, up1;
    assign up2 = s1_row0_reg ? s1_px_reg : lb_rd[2*PIX_W-1:PIX_W];
    assign up1 = s1_row0_reg ? s1_px_reg : lb_rd[PIX_W-1:0];

    c3rb_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (IW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_i),
        .rd_data (lb_rd),
        .wr_en   (s1_go),
        .wr_addr (s1_i_reg),
        .wr_data ({up1, s1_px_reg})
    );

    // 3x3 window, column 0 oldest; left edge replicated on column 0
    pix_t win_reg [9];
    pix_t vcol [3];
    assign vcol[0] = up2;
    assign vcol[1] = up1;
    assign vcol[2] = s1_px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (s1_go)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (s1_i_reg == '0)
                begin
                    win_reg[r*3]   <= vcol[r];
                    win_reg[r*3+1] <= vcol[r];
                end
                else
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[r*3+2] <= vcol[r];
            end
        end
    end

    // emitter: one pending result per cycle while the pipeline advances, lowest kind first
    logic [IW-1:0]         job_i_reg;
    logic [FH_W-1:0]       job_j_reg;
    logic [EMIT_KINDS-1:0] pick;
    logic                  issue;

    assign pick  = pend_reg & (~pend_reg + EMIT_KINDS'(1));
    assign issue = adv && (pend_reg != '0);

    always_comb
    begin
        pend_next = pend_reg;
        if (s1_go)
            pend_next = s1_emask_reg;
        else if (issue)
            pend_next = pend_reg & ~pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            job_i_reg <= s1_i_reg;
            job_j_reg <= s1_j_reg;
        end
    end

    logic row_edge, col_edge;
    assign row_edge = pick[EMIT_LAST_ROW] || pick[EMIT_FRAME_END];
    assign col_edge = pick[EMIT_ROW_END]  || pick[EMIT_FRAME_END];

    // tap-select stage
    logic            e_valid_reg;
    pix_t            e_tap_reg [9];
    logic [IW-1:0]   e_x_reg;
    logic [FH_W-1:0] e_y_reg;
    logic            e_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    e_tap_reg[r*3+c] <= win_reg[int'(tap_sel(row_edge, 2'(r))) * 3
                                                + int'(tap_sel(col_edge, 2'(c)))];
            e_x_reg    <= col_edge ? job_i_reg : job_i_reg - IW'(1);
            e_y_reg    <= row_edge ? job_j_reg : job_j_reg - FH_W'(1);
            e_last_reg <= pick[EMIT_FRAME_END];
        end
    end

    // lanes: products then sums
    coef_t           coefs [9];
    sample_t         lane_taps [NLANE][9];
    res_t            lane_sum [NLANE];
    logic            p_valid_reg, s_valid_reg;
    logic [IW-1:0]   p_x_reg, s_x_reg;
    logic [FH_W-1:0] p_y_reg, s_y_reg;
    logic            p_last_reg, s_last_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                coefs[r*3+c] = krow_reg[r][c*COEF_W +: COEF_W];
        for (int l = 0; l < NLANE; l++)
            for (int k = 0; k < 9; k++)
                lane_taps[l][k] = e_tap_reg[k][l*SAMPLE_W +: SAMPLE_W];
    end

    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        c3rb_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .taps  (lane_taps[l]),
            .coefs (coefs),
            .sum   (lane_sum[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= issue;
            p_valid_reg <= e_valid_reg;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_x_reg    <= e_x_reg;
            p_y_reg    <= e_y_reg;
            p_last_reg <= e_last_reg;
            s_x_reg    <= p_x_reg;
            s_y_reg    <= p_y_reg;
            s_last_reg <= p_last_reg;
        end
    end

    // merge and output register
    res_t merged [NUM_CH];

    c3rb_merge #(
        .NLANE (NLANE)
    ) u_merge (
        .lane_sum (lane_sum),
        .keep     (keep_reg),
        .nch      (nch),
        .res      (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_out.pos_x      <= POS_X_W'(s_x_reg);
            res_out.pos_y      <= s_y_reg;
            res_out.result_ch0 <= merged[0];
            res_out.result_ch1 <= merged[1];
            res_out.result_ch2 <= merged[2];
            res_out.frame_end  <= s_last_reg;
        end
    end

    assign res_out.valid = out_valid_reg;

endmodule

@@ tb/sv/tb_conv3x3_replicate_border_top.sv @@
// ----------------------------------------------------------------------------
// tb_conv3x3_replicate_border_top
// Self-checking bench for the 3x3 replicate-border convolution. Pixels go in
// through a valid/ready source with random gaps, results are checked in order
// against a behavioral model of the filter kept inside the bench.
// ----------------------------------------------------------------------------
module tb_conv3x3_replicate_border_top;
    timeunit 1ns;
    timeprecision 1ps;
    import c3rb_pkg::*;

    // one filtered output pixel
    typedef struct packed {
        logic [POS_X_W-1:0] px;
        logic [POS_Y_W-1:0] py;
        logic [RES_W-1:0]   r0;
        logic [RES_W-1:0]   r1;
        logic [RES_W-1:0]   r2;
        logic               fe;
    } filt_px_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    c3rb_cfg_if cfg();
    c3rb_pix_if pix();
    c3rb_res_if res();

    conv3x3_replicate_border_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pix_in  (pix),
        .res_out (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- predictor state: shadow of registers, line stores, window ----
    logic [KROW_W-1:0] krow [3];
    logic              keep_ch;
    logic [FW_W-1:0]   fr_w;
    logic [FH_W-1:0]   fr_h;
    logic [CC_W-1:0]   ch_cnt;
    pix_t              line_old [1024];
    pix_t              line_new [1024];
    pix_t              win [9];
    int unsigned       col_cnt, row_cnt;

    filt_px_t expected_px[$];
    int  errors = 0;
    bit  gaps_on = 1'b1;    // random idling on both sides
    int  hold_cycles = 0;   // long receiver hold-off, counted by the sink

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic signed [COEF_W-1:0] kcoef(int r, int c);
        return krow[r][16*c +: 16];
    endfunction

    function automatic filt_px_t filter_at(int unsigned x, int unsigned y, bit erow,
                                           bit ecol, bit last);
        filt_px_t o;
        longint acc, sum [3];
        int nch, rr, cc;
        pix_t p;
        sum = '{0, 0, 0};
        nch = (ch_cnt == 0) ? 1 : ch_cnt;
        for (int ch = 0; ch < nch; ch++)
        begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    rr = erow ? ((r == 0) ? 1 : 2) : r;
                    cc = ecol ? ((c == 0) ? 1 : 2) : c;
                    p = win[rr*3 + cc];
                    acc += longint'(kcoef(r, c)) * longint'(p[8*ch +: 8]);
                end
            if (keep_ch) sum[ch] = acc;
            else sum[0] += acc;
        end
        o.px = x[POS_X_W-1:0];
        o.py = y[POS_Y_W-1:0];
        o.r0 = sum[0][RES_W-1:0];
        o.r1 = sum[1][RES_W-1:0];
        o.r2 = sum[2][RES_W-1:0];
        o.fe = last;
        return o;
    endfunction

    // advance the model by one accepted pixel and queue what it produces
    task automatic predict_filter(input pix_t p);
        int unsigned w, h, i, j;
        pix_t up2, up1, v;
        w = fr_w; h = fr_h;
        if (w < 2) w = 2;
        if (w > 1024) w = 1024;
        if (h < 2) h = 2;
        i = (col_cnt >= w) ? w - 1 : col_cnt;
        j = (row_cnt >= h) ? h - 1 : row_cnt;
        if (j == 0)
        begin
            up2 = p; up1 = p;
        end
        else
        begin
            up2 = line_old[i]; up1 = line_new[i];
        end
        line_old[i] = up1;
        line_new[i] = p;
        for (int r = 0; r < 3; r++)
        begin
            v = (r == 0) ? up2 : (r == 1) ? up1 : p;
            if (i == 0)
            begin
                win[r*3] = v; win[r*3+1] = v;
            end
            else
            begin
                win[r*3] = win[r*3+1]; win[r*3+1] = win[r*3+2];
            end
            win[r*3+2] = v;
        end
        if (j >= 1)
        begin
            if (i >= 1) expected_px.push_back(filter_at(i-1, j-1, 0, 0, 0));
            if (i == w-1) expected_px.push_back(filter_at(i, j-1, 0, 1, 0));
            if (j == h-1)
            begin
                if (i >= 1) expected_px.push_back(filter_at(i-1, j, 1, 0, 0));
                if (i == w-1) expected_px.push_back(filter_at(i, j, 1, 1, 1));
            end
        end
        if (i == w-1)
        begin
            col_cnt = 0;
            row_cnt = (j == h-1) ? 0 : ((j + 1) & 16'hFFFF);
        end
        else
        begin
            col_cnt = (i + 1) & 10'h3FF;
            row_cnt = j;
        end
    endtask

    task automatic idle_burst();
        if (gaps_on && $urandom_range(3) == 0)
            repeat ($urandom_range(7, 1)) @(posedge clk);
    endtask

    // register write; only called with the pipeline drained
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_KROW_TOP:    krow[0] = d;
            REG_KROW_MID:    krow[1] = d;
            REG_KROW_BOTTOM: krow[2] = d;
            REG_KEEP_CH:     keep_ch = d[0];
            REG_FRAME_W:     fr_w = d[FW_W-1:0];
            REG_FRAME_H:     fr_h = d[FH_W-1:0];
            REG_CH_COUNT:    ch_cnt = d[CC_W-1:0];
            default: ;
        endcase
    endtask

    // one pixel transfer; valid held across back-to-back sends
    task automatic send_pixel(input pix_t p);
        pix.valid <= 1'b1;
        pix.sample_ch0 <= p[7:0];
        pix.sample_ch1 <= p[15:8];
        pix.sample_ch2 <= p[23:16];
        do @(posedge clk); while (!pix.ready);
        predict_filter(p);
        if (gaps_on && $urandom_range(3) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
    endtask

    task automatic end_stream();
        pix.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every queued result has come, then let the pipe go quiet
    task automatic drain();
        end_stream();
        while (expected_px.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic pix_t rand_pix();
        return pix_t'($urandom());
    endfunction

    task automatic send_frame(input int w, input int h, input bit extreme);
        for (int k = 0; k < w*h; k++)
            send_pixel(extreme ? ((k % 2) ? 24'hFFFFFF : 24'h000000) : rand_pix());
    endtask

    // ---- result sink: random stalls plus a long hold-off on request ----
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= !gaps_on || ($urandom_range(4) != 0);
    end

    always @(posedge clk)
    begin
        filt_px_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_px.size() == 0)
                report($sformatf("unexpected result at (%0d,%0d)", res.pos_x, res.pos_y));
            else
            begin
                e = expected_px.pop_front();
                if (res.pos_x !== e.px)
                    report($sformatf("pos_x %0d want %0d", res.pos_x, e.px));
                if (res.pos_y !== e.py)
                    report($sformatf("pos_y %0d want %0d", res.pos_y, e.py));
                if (res.result_ch0 !== e.r0)
                    report($sformatf("ch0 at (%0d,%0d) %h want %h",
                                     e.px, e.py, res.result_ch0, e.r0));
                if (res.result_ch1 !== e.r1)
                    report($sformatf("ch1 at (%0d,%0d) %h want %h",
                                     e.px, e.py, res.result_ch1, e.r1));
                if (res.result_ch2 !== e.r2)
                    report($sformatf("ch2 at (%0d,%0d) %h want %h",
                                     e.px, e.py, res.result_ch2, e.r2));
                if (res.frame_end !== e.fe)
                    report($sformatf("frame_end at (%0d,%0d) %b", e.px, e.py, res.frame_end));
            end
        end
    end

    // ---- tests ----
    task automatic test_extremes();
        // widest coefficients, 2x2 frame, saturated and empty pixels
        write_reg(REG_KROW_TOP,    48'h7FFF_8000_0001);
        write_reg(REG_KROW_MID,    48'hFFFF_7FFF_8000);
        write_reg(REG_KROW_BOTTOM, 48'h0100_FF00_7FFF);
        write_reg(REG_FRAME_W, CFG_DAT_W'(2));
        write_reg(REG_FRAME_H, CFG_DAT_W'(2));
        send_frame(2, 2, 1);
        drain();
        write_reg(REG_KEEP_CH, CFG_DAT_W'(0));
        send_frame(2, 2, 1);
        drain();
        write_reg(REG_KEEP_CH, CFG_DAT_W'(1));
    endtask

    task automatic test_bad_sizes();
        // width 0 and height 1 clamp to 2, channel count 0 acts as 1
        write_reg(REG_FRAME_W, CFG_DAT_W'(0));
        write_reg(REG_FRAME_H, CFG_DAT_W'(1));
        write_reg(REG_CH_COUNT, CFG_DAT_W'(0));
        send_frame(2, 2, 0);
        drain();
        write_reg(REG_FRAME_W, CFG_DAT_W'(11'h7FF));   // clamps to max width; partial row
        write_reg(REG_CH_COUNT, CFG_DAT_W'(2));
        for (int k = 0; k < 5; k++) send_pixel(rand_pix());
        drain();
        write_reg(REG_FRAME_W, CFG_DAT_W'(3));        // shrink mid-frame: column past end
        write_reg(REG_FRAME_H, CFG_DAT_W'(16'hFFFF));
        for (int k = 0; k < 4; k++) send_pixel(rand_pix());
        drain();
        write_reg(REG_FRAME_H, CFG_DAT_W'(2));        // row counter beyond height
        send_pixel(rand_pix());
        drain();
    endtask

    task automatic test_random_frames();
        int w, h;
        for (int f = 0; f < 12; f++)
        begin
            write_reg(REG_KROW_TOP,    CFG_DAT_W'({$urandom(), $urandom()}));
            write_reg(REG_KROW_MID,    CFG_DAT_W'({$urandom(), $urandom()}));
            write_reg(REG_KROW_BOTTOM, CFG_DAT_W'({$urandom(), $urandom()}));
            write_reg(REG_KEEP_CH, CFG_DAT_W'($urandom_range(1)));
            write_reg(REG_CH_COUNT, CFG_DAT_W'($urandom_range(3)));
            w = $urandom_range(4, 2);
            h = $urandom_range(3, 2);
            write_reg(REG_FRAME_W, CFG_DAT_W'(w));
            write_reg(REG_FRAME_H, CFG_DAT_W'(h));
            send_frame(w, h, 0);
            drain();
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while pixels keep coming: input must stall
        write_reg(REG_FRAME_W, CFG_DAT_W'(4));
        write_reg(REG_FRAME_H, CFG_DAT_W'(4));
        write_reg(REG_CH_COUNT, CFG_DAT_W'(3));
        @(posedge clk);
        hold_cycles <= 60;
        send_frame(4, 4, 0);
        drain();
    endtask

    task automatic test_steady();
        // no idling: full-rate stream
        gaps_on = 1'b0;
        write_reg(REG_FRAME_W, CFG_DAT_W'(5));
        write_reg(REG_FRAME_H, CFG_DAT_W'(3));
        send_frame(5, 3, 0);
        drain();
    endtask

    initial
    begin
        cfg.valid = 1'b0; cfg.index = REG_KROW_TOP; cfg.data = '0;
        pix.valid = 1'b0; pix.sample_ch0 = '0; pix.sample_ch1 = '0; pix.sample_ch2 = '0;
        krow = '{default: '0};
        keep_ch = 1'b1; fr_w = 640; fr_h = 480; ch_cnt = 3;
        win = '{default: '0};
        col_cnt = 0; row_cnt = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_bad_sizes();
        test_random_frames();
        test_backpressure();
        test_steady();
        if (errors == 0)
            $display("[conv3x3_replicate_border_top] OK");
        else
            $display("[conv3x3_replicate_border_top] ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[conv3x3_replicate_border_top] ERROR");
        $finish;
    end
endmodule
